FILE: hw/rtl/hcc_pkg.sv
// Shared types and constants of the hysteretic current chopper.
`default_nettype none

package hcc_pkg;

    // Command codes carried by each request.
    localparam logic [2:0] CMD_SAMPLE        = 3'd0;
    localparam logic [2:0] CMD_SET_TARGET    = 3'd1;
    localparam logic [2:0] CMD_SET_DIRECTION = 3'd2;
    localparam logic [2:0] CMD_START         = 3'd3;
    localparam logic [2:0] CMD_STOP          = 3'd4;

    localparam logic [4:0]  MONITORED_CHANNEL = 5'd0;
    localparam logic [15:0] HYSTERESIS_RESET  = 16'd65;
    localparam logic [15:0] THRESHOLD_RESET   = 16'hFFFF;

    // Configuration space: two 32-bit registers at byte addresses 0 and 4.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic REG_BASELINE   = 1'b0;
    localparam logic REG_HYSTERESIS = 1'b1;

    typedef struct packed {
        logic [2:0]         command;
        logic [11:0]        sample_value;
        logic [4:0]         sample_channel;
        logic signed [15:0] target_value;
        logic               direction_value;
    } t_req;

    typedef struct packed {
        logic        drive_forward;
        logic        drive_reverse;
        logic        indicator;
        logic        tripped;
        logic [15:0] threshold;
    } t_rsp;

    typedef struct packed {
        logic [15:0] current_baseline;
        logic [15:0] hysteresis_band;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hw/rtl/hcc_req_if.sv
// Valid/ready channel that carries chopper requests.
`default_nettype none

interface hcc_req_if;
    import hcc_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hcc_rsp_if.sv
// Valid/ready channel that carries chopper results.
`default_nettype none

interface hcc_rsp_if;
    import hcc_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hcc_apb_regs.sv
// APB configuration registers of the chopper: baseline and hysteresis band.
`default_nettype none

module hcc_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hcc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output hcc_pkg::t_cfg                      o_cfg
);
    import hcc_pkg::*;

    logic [15:0] r_baseline;
    logic [15:0] r_hysteresis;
    logic        wr_en;
    logic        reg_sel;

    // Registers sit on 4-byte boundaries, so bit 2 picks the register.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline   <= '0;
            r_hysteresis <= HYSTERESIS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BASELINE:   r_baseline   <= pwdata[15:0];
                REG_HYSTERESIS: r_hysteresis <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BASELINE:   prdata = {16'd0, r_baseline};
            REG_HYSTERESIS: prdata = {16'd0, r_hysteresis};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.current_baseline = r_baseline;
    assign o_cfg.hysteresis_band  = r_hysteresis;

endmodule

`default_nettype wire

FILE: hw/rtl/hcc_core.sv
// Chopper state and the combinational next-state and result logic.
`default_nettype none

module hcc_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hcc_pkg::t_cfg i_cfg,
    input  wire logic          i_step,
    input  wire hcc_pkg::t_req i_req,
    output hcc_pkg::t_rsp      o_rsp
);
    import hcc_pkg::*;

    logic        r_direction, n_direction;
    logic [15:0] r_target, n_target;
    logic [15:0] r_threshold, n_threshold;
    logic        r_running, n_running;
    logic        r_forward_on, n_forward_on;
    logic        r_reverse_on, n_reverse_on;
    logic        r_lamp_on, n_lamp_on;
    logic        tripped;

    logic        go_forward;
    logic        sample_trip;
    logic [15:0] base_hyst;
    logic [15:0] thr_forward;
    logic [15:0] thr_reverse;

    // Thresholds wrap at 16 bits by construction.
    assign base_hyst   = i_cfg.current_baseline + i_cfg.hysteresis_band;
    assign thr_forward = base_hyst + r_target;
    assign thr_reverse = base_hyst - r_target;
    assign go_forward  = !r_target[15] ^ r_direction;
    assign sample_trip = r_running && (i_req.sample_channel == MONITORED_CHANNEL)
                         && (i_req.sample_value > r_threshold[11:0]);

    always_comb begin
        n_direction  = r_direction;
        n_target     = r_target;
        n_threshold  = r_threshold;
        n_running    = r_running;
        n_forward_on = r_forward_on;
        n_reverse_on = r_reverse_on;
        n_lamp_on    = r_lamp_on;
        tripped      = 1'b0;
        unique case (i_req.command)
            CMD_SAMPLE: begin
                if (sample_trip) begin
                    tripped      = 1'b1;
                    n_forward_on = go_forward;
                    n_reverse_on = !go_forward;
                    n_threshold  = go_forward ? thr_forward : thr_reverse;
                    n_direction  = !r_direction;
                    n_lamp_on    = !r_direction;
                end
            end
            CMD_SET_TARGET:    n_target    = i_req.target_value;
            CMD_SET_DIRECTION: n_direction = i_req.direction_value;
            CMD_START: begin
                // Start zeroes the target, sets the direction bit and always trips forward.
                tripped      = 1'b1;
                n_target     = '0;
                n_running    = 1'b1;
                n_forward_on = 1'b1;
                n_reverse_on = 1'b0;
                n_threshold  = base_hyst;
                n_direction  = 1'b1;
                n_lamp_on    = 1'b1;
            end
            CMD_STOP: begin
                n_running    = 1'b0;
                n_forward_on = 1'b0;
                n_reverse_on = 1'b0;
                n_target     = '0;
                n_direction  = 1'b0;
                n_lamp_on    = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_target     <= '0;
            r_threshold  <= THRESHOLD_RESET;
            r_running    <= 1'b0;
            r_forward_on <= 1'b0;
            r_reverse_on <= 1'b0;
            r_lamp_on    <= 1'b0;
        end else if (i_step) begin
            r_direction  <= n_direction;
            r_target     <= n_target;
            r_threshold  <= n_threshold;
            r_running    <= n_running;
            r_forward_on <= n_forward_on;
            r_reverse_on <= n_reverse_on;
            r_lamp_on    <= n_lamp_on;
        end
    end

    assign o_rsp.drive_forward = n_forward_on;
    assign o_rsp.drive_reverse = n_reverse_on;
    assign o_rsp.indicator     = n_lamp_on;
    assign o_rsp.tripped       = tripped;
    assign o_rsp.threshold     = n_threshold;

    // Both switches on at once would short the supply.
    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_forward_on && r_reverse_on))
        else $error("both switches on");

    // A stopped chopper never drives the winding.
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (!r_forward_on && !r_reverse_on))
        else $error("switch on while stopped");

    // A trip leaves exactly one switch on and the lamp following direction.
    a_trip_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && tripped) |=> ((r_forward_on ^ r_reverse_on) && (r_lamp_on == r_direction)))
        else $error("trip left bad switch state");

endmodule

`default_nettype wire

FILE: hw/rtl/hysteretic_current_chopper.sv
// Top level of the hysteretic current chopper: request and result registers.
// Each request carries one command (sample, set target, set direction, start,
// stop) and produces exactly one result giving the switch drives, the lamp,
// whether the request tripped, and the current 16-bit threshold. A request is
// captured into an input register, evaluated combinationally against the
// chopper state, and the result lands in an output register, so a request is
// accepted every cycle unless both registers are full; the result is offered
// from the output register until the result side is ready. The combinational
// path is one 16-bit three-term add and a 12-bit compare in hcc_core. The
// output register decouples the two sides: the input register keeps taking
// requests while a result waits, and stalls only when both registers are
// full. Configuration (baseline at byte address 0, hysteresis band at 4) is to
// be written through the APB port by the user while no request is in flight;
// the block itself does not enforce this.
`default_nettype none

module hysteretic_current_chopper (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    hcc_req_if.sink                             i_req,
    hcc_rsp_if.source                           o_rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hcc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    import hcc_pkg::*;

    t_cfg cfg;
    t_rsp core_rsp;

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;

    logic out_free;
    logic step;
    logic take_in;

    hcc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The held request is evaluated in the cycle it moves to the output
    // register, which is also when the chopper state advances.
    assign out_free = !r_out_valid || o_rsp.ready;
    assign step     = r_in_valid && out_free;
    assign take_in  = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_valid || step;

    hcc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_req   (r_in),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_req.payload;
        end
        if (step) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // A held request is never dropped while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in)))
        else $error("held request lost during stall");

    // Every evaluated request becomes a visible result in the next cycle.
    a_step_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("evaluated request produced no result");

    // A new request is only taken when the input register has room.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_in && r_in_valid) |-> step)
        else $error("request overwrote a held request");

endmodule

`default_nettype wire
